// ----- rtl/core/bfra_pkg.sv -----
package bfra_pkg;

   localparam int HEAP_DEPTH  = 1024;
   localparam int MAX_RANGES  = 512;
   localparam int STALE_DEPTH = 256;

   localparam int CNT_W   = 11;
   localparam int OFF_W   = 10;
   localparam int IDX_W   = 9;
   localparam int SPTR_W  = 8;
   localparam int FILL_W  = 9;
   localparam int AGE_W   = 32;
   localparam int HND_W   = 64;
   localparam int STRD_W  = 16;
   localparam int PROD_W  = OFF_W + STRD_W;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] CSR_HEAP_SLOTS    = 2'd0;
   localparam logic [1:0] CSR_BASE_HANDLE   = 2'd1;
   localparam logic [1:0] CSR_HANDLE_STRIDE = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [OFF_W-1:0] start;
      logic [CNT_W-1:0] length;
      logic [AGE_W-1:0] age;
   } range_entry_type;

   typedef struct packed {
      logic [CNT_W-1:0] start;
      logic [CNT_W-1:0] length;
      logic [HND_W-1:0] frame;
   } stale_entry_type;

endpackage

// ----- rtl/core/best_fit_range_allocator_deferred_free.sv -----
// Best-fit range allocator with frame-deferred freeing.
// The request channel (req_*) carries one transaction per item: allocate,
// queue a free with its frame number, or release queued frees up to a frame.
// The response channel (rsp_*) returns one transaction per request, but
// a heap size write drops a request in flight. Both channels use valid
// and stall; a transaction moves when valid is high and stall is low.
// The csr_* port writes heap size, base handle and stride. One item at a
// time is worked on; req_stall is high while it is in flight. An allocate
// scans all 512 range table entries through one memory read port.
// A release scans the range table for each queued entry it takes and drops
// each malformed entry without a scan. A free runs a bit-serial divider
// before it responds; a zero allocate, an unknown action or a full stale
// queue goes straight to the response.
// The response register holds a finished result while rsp_stall is high;
// the next request can be taken in the cycle after the result has been loaded there.
// After reset, and after every heap size write, a clearing pass sweeps all
// 512 range table entries and the request side stays stalled.
module best_fit_range_allocator_deferred_free
   import bfra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_action,
   input  logic [CNT_W-1:0] req_slot_count,
   input  logic [HND_W-1:0] req_freed_handle,
   input  logic [HND_W-1:0] req_frame_number,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [HND_W-1:0] rsp_granted_handle,
   output logic [CNT_W-1:0] rsp_granted_count,
   output logic [CNT_W-1:0] rsp_free_slots,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [HND_W-1:0] csr_data
);

   typedef enum logic [13:0] {
      ST_CLEAR  = 14'b00000000000001,
      ST_IDLE   = 14'b00000000000010,
      ST_START  = 14'b00000000000100,
      ST_ASCAN  = 14'b00000000001000,
      ST_ADEC   = 14'b00000000010000,
      ST_AADD   = 14'b00000000100000,
      ST_DIV    = 14'b00000001000000,
      ST_FPUSH  = 14'b00000010000000,
      ST_RWAIT  = 14'b00000100000000,
      ST_RCHK   = 14'b00001000000000,
      ST_RSCAN  = 14'b00010000000000,
      ST_RDEC   = 14'b00100000000000,
      ST_RPUT   = 14'b01000000000000,
      ST_FINISH = 14'b10000000000000
   } state_type;

   range_entry_type range_mem [MAX_RANGES];
   stale_entry_type stale_mem [STALE_DEPTH];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] heap_size_ff, heap_size_in;
   logic [HND_W-1:0] base_ff, base_in;
   logic [STRD_W-1:0] stride_ff, stride_in;
   logic [AGE_W-1:0] seq_ff, seq_in;
   logic [CNT_W-1:0] free_total_ff, free_total_in;
   logic [SPTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             issue_done_ff, issue_done_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [1:0]       act_ff, act_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HND_W-1:0] freed_ff, freed_in;
   logic [HND_W-1:0] frame_ff, frame_in;
   logic             best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [CNT_W-1:0] best_len_ff, best_len_in;
   logic [OFF_W-1:0] best_start_ff, best_start_in;
   logic [AGE_W-1:0] best_dist_ff, best_dist_in;
   logic             ovl_ff, ovl_in;
   logic             prev_found_ff, prev_found_in;
   logic [IDX_W-1:0] prev_idx_ff, prev_idx_in;
   logic [OFF_W-1:0] prev_start_ff, prev_start_in;
   logic [CNT_W-1:0] prev_len_ff, prev_len_in;
   logic             next_found_ff, next_found_in;
   logic [IDX_W-1:0] next_idx_ff, next_idx_in;
   logic [CNT_W-1:0] next_len_ff, next_len_in;
   logic             slot_found_ff, slot_found_in;
   logic [IDX_W-1:0] slot_idx_ff, slot_idx_in;
   logic [OFF_W-1:0] m_off_ff, m_off_in;
   logic [CNT_W-1:0] m_len_ff, m_len_in;
   logic [IDX_W-1:0] m_slot_ff, m_slot_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [HND_W-1:0] quo_ff, quo_in;
   logic [STRD_W-1:0] rem_ff, rem_in;
   logic [5:0]       div_cnt_ff, div_cnt_in;
   logic [1:0]       status_ff, status_in;
   logic [HND_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0] granted_ff, granted_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [HND_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0] rsp_free_ff, rsp_free_in;

   range_entry_type  range_rdata_ff;
   stale_entry_type  stale_rdata_ff;
   logic             range_we;
   logic [IDX_W-1:0] range_waddr;
   logic [IDX_W-1:0] range_raddr;
   range_entry_type  range_wdata;
   logic             stale_we;
   stale_entry_type  stale_wdata;

   logic [STRD_W-1:0] stride_eff;
   logic [AGE_W-1:0] age_dist;
   logic [CNT_W:0]   e_end;
   logic [CNT_W:0]   r_end;
   logic [STRD_W:0]  trial;
   logic [STRD_W:0]  trial_sub;
   logic             rel_bad;
   logic [CNT_W-1:0] left;
   logic [CNT_W-1:0] heap_new;

   assign stride_eff = (stride_ff == '0) ? STRD_W'(1) : stride_ff;
   assign age_dist   = seq_ff - range_rdata_ff.age;
   assign e_end      = {1'b0, 1'b0, range_rdata_ff.start} + {1'b0, range_rdata_ff.length};
   assign r_end      = {1'b0, stale_rdata_ff.start} + {1'b0, stale_rdata_ff.length};
   assign trial      = {rem_ff, quo_ff[HND_W-1]};
   assign trial_sub  = trial - {1'b0, stride_eff};
   assign rel_bad    = (stale_rdata_ff.length == '0) ||
                       (stale_rdata_ff.start >= heap_size_ff) ||
                       (stale_rdata_ff.length > (heap_size_ff - stale_rdata_ff.start));
   assign left       = best_len_ff - cnt_ff;
   assign heap_new   = (csr_data[CNT_W-1:0] > CNT_W'(HEAP_DEPTH)) ?
                       CNT_W'(HEAP_DEPTH) : csr_data[CNT_W-1:0];

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_handle = rsp_handle_ff;
   assign rsp_granted_count  = rsp_count_ff;
   assign rsp_free_slots     = rsp_free_ff;

   always_comb begin
      state_in      = state_ff;
      heap_size_in  = heap_size_ff;
      base_in       = base_ff;
      stride_in     = stride_ff;
      seq_in        = seq_ff;
      free_total_in = free_total_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      act_in        = act_ff;
      cnt_in        = cnt_ff;
      freed_in      = freed_ff;
      frame_in      = frame_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      best_dist_in  = best_dist_ff;
      ovl_in        = ovl_ff;
      prev_found_in = prev_found_ff;
      prev_idx_in   = prev_idx_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      next_found_in = next_found_ff;
      next_idx_in   = next_idx_ff;
      next_len_in   = next_len_ff;
      slot_found_in = slot_found_ff;
      slot_idx_in   = slot_idx_ff;
      m_off_in      = m_off_ff;
      m_len_in      = m_len_ff;
      m_slot_in     = m_slot_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      status_in     = status_ff;
      handle_in     = handle_ff;
      granted_in    = granted_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_free_in   = rsp_free_ff;
      range_we      = 1'b0;
      range_waddr   = scan_idx_ff;
      range_raddr   = scan_idx_ff;
      range_wdata   = '0;
      stale_we      = 1'b0;
      stale_wdata   = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if ((state_ff == ST_ASCAN) || (state_ff == ST_RSCAN)) begin
         if (!issue_done_ff) begin
            chk_in     = 1'b1;
            chk_idx_in = scan_idx_ff;
            if (scan_idx_ff == IDX_W'(MAX_RANGES - 1)) begin
               issue_done_in = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            range_we    = 1'b1;
            range_waddr = scan_idx_ff;
            if ((scan_idx_ff == '0) && (heap_size_ff != '0)) begin
               range_wdata.valid  = 1'b1;
               range_wdata.start  = '0;
               range_wdata.length = heap_size_ff;
               range_wdata.age    = seq_ff;
               seq_in             = seq_ff + AGE_W'(1);
            end
            if (scan_idx_ff == IDX_W'(MAX_RANGES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               cnt_in   = req_slot_count;
               freed_in = req_freed_handle;
               frame_in = req_frame_number;
               state_in = ST_START;
            end
         end
         ST_START: begin
            status_in     = STATUS_OK;
            handle_in     = '0;
            granted_in    = '0;
            scan_idx_in   = '0;
            issue_done_in = 1'b0;
            unique case (act_ff)
               ACT_ALLOC: begin
                  best_found_in = 1'b0;
                  state_in      = (cnt_ff == '0) ? ST_FINISH : ST_ASCAN;
               end
               ACT_FREE: begin
                  if (fill_ff >= FILL_W'(STALE_DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_FINISH;
                  end else begin
                     quo_in     = freed_ff - base_ff;
                     rem_in     = '0;
                     div_cnt_in = '0;
                     state_in   = ST_DIV;
                  end
               end
               ACT_RELEASE: begin
                  state_in = ST_RWAIT;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_ASCAN: begin
            if (chk_ff && range_rdata_ff.valid && (range_rdata_ff.length >= cnt_ff)) begin
               if (!best_found_ff || (range_rdata_ff.length < best_len_ff) ||
                   ((range_rdata_ff.length == best_len_ff) && (age_dist > best_dist_ff)))
               begin
                  best_found_in = 1'b1;
                  best_idx_in   = chk_idx_ff;
                  best_len_in   = range_rdata_ff.length;
                  best_start_in = range_rdata_ff.start;
                  best_dist_in  = age_dist;
               end
            end
            if (issue_done_ff && !chk_ff) begin
               state_in = ST_ADEC;
            end
         end
         ST_ADEC: begin
            if (!best_found_ff) begin
               status_in = STATUS_NOFIT;
               state_in  = ST_FINISH;
            end else begin
               range_we    = 1'b1;
               range_waddr = best_idx_ff;
               if (left != '0) begin
                  range_wdata.valid  = 1'b1;
                  range_wdata.start  = best_start_ff + cnt_ff[OFF_W-1:0];
                  range_wdata.length = left;
                  range_wdata.age    = seq_ff;
                  seq_in             = seq_ff + AGE_W'(1);
               end
               free_total_in = free_total_ff - cnt_ff;
               prod_in       = PROD_W'(best_start_ff) * PROD_W'(stride_ff);
               granted_in    = cnt_ff;
               state_in      = ST_AADD;
            end
         end
         ST_AADD: begin
            handle_in = base_ff + HND_W'(prod_ff);
            state_in  = ST_FINISH;
         end
         ST_DIV: begin
            if (trial >= {1'b0, stride_eff}) begin
               rem_in = trial_sub[STRD_W-1:0];
               quo_in = {quo_ff[HND_W-2:0], 1'b1};
            end else begin
               rem_in = trial[STRD_W-1:0];
               quo_in = {quo_ff[HND_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd63) begin
               state_in = ST_FPUSH;
            end
         end
         ST_FPUSH: begin
            stale_we           = 1'b1;
            stale_wdata.start  = (quo_ff[HND_W-1:CNT_W] != '0) ? '1 : quo_ff[CNT_W-1:0];
            stale_wdata.length = cnt_ff;
            stale_wdata.frame  = frame_ff;
            tail_in            = tail_ff + SPTR_W'(1);
            fill_in            = fill_ff + FILL_W'(1);
            state_in           = ST_FINISH;
         end
         ST_RWAIT: begin
            state_in = ST_RCHK;
         end
         ST_RCHK: begin
            if ((fill_ff == '0) || (stale_rdata_ff.frame > frame_ff)) begin
               state_in = ST_FINISH;
            end else if (rel_bad) begin
               head_in  = head_ff + SPTR_W'(1);
               fill_in  = fill_ff - FILL_W'(1);
               state_in = ST_RWAIT;
            end else begin
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               ovl_in        = 1'b0;
               prev_found_in = 1'b0;
               next_found_in = 1'b0;
               slot_found_in = 1'b0;
               state_in      = ST_RSCAN;
            end
         end
         ST_RSCAN: begin
            if (chk_ff) begin
               if (range_rdata_ff.valid) begin
                  if (({2'b0, range_rdata_ff.start} < r_end) &&
                      ({1'b0, stale_rdata_ff.start} < e_end)) begin
                     ovl_in = 1'b1;
                  end
                  if (e_end == {1'b0, stale_rdata_ff.start}) begin
                     prev_found_in = 1'b1;
                     prev_idx_in   = chk_idx_ff;
                     prev_start_in = range_rdata_ff.start;
                     prev_len_in   = range_rdata_ff.length;
                  end
                  if ({2'b0, range_rdata_ff.start} == r_end) begin
                     next_found_in = 1'b1;
                     next_idx_in   = chk_idx_ff;
                     next_len_in   = range_rdata_ff.length;
                  end
               end else if (!slot_found_ff) begin
                  slot_found_in = 1'b1;
                  slot_idx_in   = chk_idx_ff;
               end
            end
            if (issue_done_ff && !chk_ff) begin
               state_in = ST_RDEC;
            end
         end
         ST_RDEC: begin
            if (ovl_ff) begin
               head_in  = head_ff + SPTR_W'(1);
               fill_in  = fill_ff - FILL_W'(1);
               state_in = ST_RWAIT;
            end else if (!prev_found_ff && !next_found_ff && !slot_found_ff) begin
               state_in = ST_FINISH;
            end else begin
               free_total_in = free_total_ff + stale_rdata_ff.length;
               m_off_in      = prev_found_ff ? prev_start_ff :
                               stale_rdata_ff.start[OFF_W-1:0];
               m_len_in      = stale_rdata_ff.length +
                               (prev_found_ff ? prev_len_ff : '0) +
                               (next_found_ff ? next_len_ff : '0);
               m_slot_in     = prev_found_ff ? prev_idx_ff :
                               (next_found_ff ? next_idx_ff : slot_idx_ff);
               if (prev_found_ff && next_found_ff) begin
                  range_we    = 1'b1;
                  range_waddr = next_idx_ff;
               end
               state_in = ST_RPUT;
            end
         end
         ST_RPUT: begin
            range_we           = 1'b1;
            range_waddr        = m_slot_ff;
            range_wdata.valid  = 1'b1;
            range_wdata.start  = m_off_ff;
            range_wdata.length = m_len_ff;
            range_wdata.age    = seq_ff;
            seq_in             = seq_ff + AGE_W'(1);
            head_in            = head_ff + SPTR_W'(1);
            fill_in            = fill_ff - FILL_W'(1);
            state_in           = ST_RWAIT;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = handle_ff;
               rsp_count_in  = granted_ff;
               rsp_free_in   = free_total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_SLOTS: begin
               heap_size_in  = heap_new;
               free_total_in = heap_new;
               head_in       = '0;
               tail_in       = '0;
               fill_in       = '0;
               scan_idx_in   = '0;
               state_in      = ST_CLEAR;
            end
            CSR_BASE_HANDLE: begin
               base_in = csr_data;
            end
            CSR_HANDLE_STRIDE: begin
               stride_in = csr_data[STRD_W-1:0];
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         heap_size_ff  <= CNT_W'(HEAP_DEPTH);
         base_ff       <= '0;
         stride_ff     <= STRD_W'(32);
         seq_ff        <= '0;
         free_total_ff <= CNT_W'(HEAP_DEPTH);
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         scan_idx_ff   <= '0;
         issue_done_ff <= 1'b0;
         chk_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_size_ff  <= heap_size_in;
         base_ff       <= base_in;
         stride_ff     <= stride_in;
         seq_ff        <= seq_in;
         free_total_ff <= free_total_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         scan_idx_ff   <= scan_idx_in;
         issue_done_ff <= issue_done_in;
         chk_ff        <= chk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      act_ff        <= act_in;
      cnt_ff        <= cnt_in;
      freed_ff      <= freed_in;
      frame_ff      <= frame_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      best_dist_ff  <= best_dist_in;
      ovl_ff        <= ovl_in;
      prev_found_ff <= prev_found_in;
      prev_idx_ff   <= prev_idx_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      next_found_ff <= next_found_in;
      next_idx_ff   <= next_idx_in;
      next_len_ff   <= next_len_in;
      slot_found_ff <= slot_found_in;
      slot_idx_ff   <= slot_idx_in;
      m_off_ff      <= m_off_in;
      m_len_ff      <= m_len_in;
      m_slot_ff     <= m_slot_in;
      prod_ff       <= prod_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      status_ff     <= status_in;
      handle_ff     <= handle_in;
      granted_ff    <= granted_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (range_we) begin
         range_mem[range_waddr] <= range_wdata;
      end
      range_rdata_ff <= range_mem[range_raddr];
   end

   always_ff @(posedge clock) begin
      if (stale_we) begin
         stale_mem[tail_ff] <= stale_wdata;
      end
      stale_rdata_ff <= stale_mem[head_ff];
   end

endmodule
